/* src/chacha20_keystream_xor_unit_assert.svh */
// Assertion macros for the keystream XOR unit.
`ifndef CHACHA20_KEYSTREAM_XOR_UNIT_ASSERT_SVH
`define CHACHA20_KEYSTREAM_XOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CC20_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* src/cc20_pkg.sv */
package cc20_pkg;

   typedef enum logic [2:0] {
      CSR_KEY_0         = 3'd0,
      CSR_KEY_1         = 3'd1,
      CSR_KEY_2         = 3'd2,
      CSR_KEY_3         = 3'd3,
      CSR_NONCE_LOW     = 3'd4,
      CSR_NONCE_HIGH    = 3'd5,
      CSR_START_COUNTER = 3'd6
   } csr_idx_type;

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   typedef struct packed {
      logic [63:0] data_in;
      logic [3:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] data_out;
      logic [3:0]  byte_count_out;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_0;
      logic [63:0] key_1;
      logic [63:0] key_2;
      logic [63:0] key_3;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
   } cfg_type;

   // One classified word on its way from the front to the back.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  byte_count;
      logic        last;
      logic [7:0]  byte_mask;
      logic [2:0]  pos;
      logic        new_block;
      logic [31:0] counter;
   } job_type;

   typedef logic [15:0][31:0] blk_type;
   typedef logic [7:0][63:0]  ks_rows_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } qr_type;

   typedef enum logic [1:0] {
      BK_SERVE,
      BK_ROUND,
      BK_FINAL
   } bk_state_type;

   typedef struct packed {
      logic busy;
      logic emit;
   } bk_status_type;

   function automatic qr_type quarter(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
      logic [31:0] ta;
      logic [31:0] tb;
      logic [31:0] tc;
      logic [31:0] td;
      ta = a + b;
      td = d ^ ta;
      td = {td[15:0], td[31:16]};
      tc = c + td;
      tb = b ^ tc;
      tb = {tb[19:0], tb[31:20]};
      ta = ta + tb;
      td = td ^ ta;
      td = {td[23:0], td[31:24]};
      tc = tc + td;
      tb = tb ^ tc;
      tb = {tb[24:0], tb[31:25]};
      return '{a: ta, b: tb, c: tc, d: td};
   endfunction

   // One column round or one diagonal round: four quarter rounds side by side.
   function automatic blk_type chacha_round(input blk_type w, input logic diag);
      qr_type  q0;
      qr_type  q1;
      qr_type  q2;
      qr_type  q3;
      blk_type r;
      r = w;
      if (!diag) begin
         q0 = quarter(w[0], w[4], w[8],  w[12]);
         q1 = quarter(w[1], w[5], w[9],  w[13]);
         q2 = quarter(w[2], w[6], w[10], w[14]);
         q3 = quarter(w[3], w[7], w[11], w[15]);
         r[0] = q0.a; r[4] = q0.b; r[8]  = q0.c; r[12] = q0.d;
         r[1] = q1.a; r[5] = q1.b; r[9]  = q1.c; r[13] = q1.d;
         r[2] = q2.a; r[6] = q2.b; r[10] = q2.c; r[14] = q2.d;
         r[3] = q3.a; r[7] = q3.b; r[11] = q3.c; r[15] = q3.d;
      end else begin
         q0 = quarter(w[0], w[5], w[10], w[15]);
         q1 = quarter(w[1], w[6], w[11], w[12]);
         q2 = quarter(w[2], w[7], w[8],  w[13]);
         q3 = quarter(w[3], w[4], w[9],  w[14]);
         r[0] = q0.a; r[5] = q0.b; r[10] = q0.c; r[15] = q0.d;
         r[1] = q1.a; r[6] = q1.b; r[11] = q1.c; r[12] = q1.d;
         r[2] = q2.a; r[7] = q2.b; r[8]  = q2.c; r[13] = q2.d;
         r[3] = q3.a; r[4] = q3.b; r[9]  = q3.c; r[14] = q3.d;
      end
      return r;
   endfunction

   // Counts of eight and above keep all bytes; zero keeps none.
   function automatic logic [7:0] byte_mask(input logic [3:0] count);
      logic [8:0] m;
      m = (9'h001 << count[2:0]) - 9'h001;
      return count[3] ? 8'hff : m[7:0];
   endfunction

endpackage

/* src/cc20_front.sv */
module cc20_front
   import cc20_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   input  logic [31:0] start_counter,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic [31:0] block_counter_ff;
   logic [31:0] block_counter_in;
   logic [2:0]  pos_ff;
   logic [2:0]  pos_in;
   logic        in_msg_ff;
   logic        in_msg_in;

   logic [31:0] ctr_sel;
   logic [2:0]  pos_sel;
   logic        new_block;

   assign q_push    = req_push && !q_full;
   assign ctr_sel   = in_msg_ff ? block_counter_ff : start_counter;
   assign pos_sel   = in_msg_ff ? pos_ff : 3'd0;
   assign new_block = (pos_sel == 3'd0);

   always_comb begin
      q_job.data       = req_data.data_in;
      q_job.byte_count = req_data.byte_count;
      q_job.last       = req_data.last;
      q_job.byte_mask  = byte_mask(req_data.byte_count);
      q_job.pos        = pos_sel;
      q_job.new_block  = new_block;
      q_job.counter    = ctr_sel;
   end

   always_comb begin
      block_counter_in = block_counter_ff;
      pos_in           = pos_ff;
      in_msg_in        = in_msg_ff;
      if (q_push) begin
         if (req_data.last) begin
            in_msg_in        = 1'b0;
            pos_in           = 3'd0;
            block_counter_in = start_counter;
         end else begin
            in_msg_in        = 1'b1;
            pos_in           = pos_sel + 3'd1;
            block_counter_in = new_block ? ctr_sel + 32'd1 : ctr_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_counter_ff <= '0;
         pos_ff           <= '0;
         in_msg_ff        <= 1'b0;
      end else begin
         block_counter_ff <= block_counter_in;
         pos_ff           <= pos_in;
         in_msg_ff        <= in_msg_in;
      end
   end

endmodule

/* src/cc20_queue.sv */
module cc20_queue
   import cc20_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* src/cc20_back.sv */
module cc20_back
   import cc20_pkg::*;
#(
   parameter int unsigned DOUBLE_ROUNDS = 10
)
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          q_empty,
   input  job_type       q_head,
   output logic          q_pop,
   output rsp_type       rsp_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output bk_status_type status
);

   localparam int unsigned ROUNDS  = 2 * DOUBLE_ROUNDS;
   localparam int unsigned ROUND_W = $clog2(ROUNDS);

   bk_state_type         state_ff;
   bk_state_type         state_in;
   logic [ROUND_W-1:0]   round_ff;
   logic [ROUND_W-1:0]   round_in;
   blk_type              w_ff;
   blk_type              init_ff;
   logic                 fresh_ff;
   logic                 fresh_in;
   rsp_type              out_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;

   blk_type              init_blk;
   ks_rows_type          ks_rows;
   logic [63:0]          mask64;
   logic                 need_gen;
   logic                 can_emit;
   logic                 start_gen;
   logic                 emit;
   logic                 out_free;

   assign out_free = !out_valid_ff || rsp_pop;
   assign need_gen = !q_empty && q_head.new_block && !fresh_ff;
   assign can_emit = !q_empty && (!q_head.new_block || fresh_ff) && out_free;
   assign ks_rows  = ks_rows_type'(w_ff);

   always_comb begin
      init_blk[0]  = SIGMA_0;
      init_blk[1]  = SIGMA_1;
      init_blk[2]  = SIGMA_2;
      init_blk[3]  = SIGMA_3;
      init_blk[4]  = cfg.key_0[31:0];
      init_blk[5]  = cfg.key_0[63:32];
      init_blk[6]  = cfg.key_1[31:0];
      init_blk[7]  = cfg.key_1[63:32];
      init_blk[8]  = cfg.key_2[31:0];
      init_blk[9]  = cfg.key_2[63:32];
      init_blk[10] = cfg.key_3[31:0];
      init_blk[11] = cfg.key_3[63:32];
      init_blk[12] = q_head.counter;
      init_blk[13] = cfg.nonce_low[31:0];
      init_blk[14] = cfg.nonce_low[63:32];
      init_blk[15] = cfg.nonce_high;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask64[8*i +: 8] = {8{q_head.byte_mask[i]}};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_SERVE: begin
            if (need_gen) begin
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = BK_FINAL;
            end
         end
         BK_FINAL: begin
            state_in = BK_SERVE;
         end
         default: begin
            state_in = BK_SERVE;
         end
      endcase
   end

   always_comb begin
      start_gen = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         BK_SERVE: begin
            start_gen = need_gen;
            emit      = can_emit;
         end
         BK_ROUND, BK_FINAL: begin
            start_gen = 1'b0;
            emit      = 1'b0;
         end
         default: begin
            start_gen = 1'b0;
            emit      = 1'b0;
         end
      endcase
   end

   assign q_pop       = emit;
   assign rsp_data    = out_ff;
   assign rsp_empty   = !out_valid_ff;
   assign status.busy = (state_ff != BK_SERVE);
   assign status.emit = emit;

   always_comb begin
      round_in = round_ff;
      if (start_gen) begin
         round_in = '0;
      end else if (state_ff == BK_ROUND) begin
         round_in = round_ff + 1'b1;
      end
   end

   always_comb begin
      fresh_in = fresh_ff;
      if (state_ff == BK_FINAL) begin
         fresh_in = 1'b1;
      end else if (emit) begin
         fresh_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SERVE;
         round_ff     <= '0;
         fresh_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Even rounds work on columns, odd rounds on diagonals; the final pass adds
   // the input block back in, leaving the keystream in the working state.
   always_ff @(posedge clock) begin
      if (start_gen) begin
         init_ff <= init_blk;
         w_ff    <= init_blk;
      end else if (state_ff == BK_ROUND) begin
         w_ff <= chacha_round(w_ff, round_ff[0]);
      end else if (state_ff == BK_FINAL) begin
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= w_ff[i] + init_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff.data_out       <= (q_head.data ^ ks_rows[q_head.pos]) & mask64;
         out_ff.byte_count_out <= q_head.byte_count;
         out_ff.last_out       <= q_head.last;
      end
   end

endmodule

/* src/chacha20_keystream_xor_unit.sv */
// ChaCha20 keystream XOR unit.
// Load the key, nonce and starting block counter through the csr_ write port
// (index 0..3 key words, 4 nonce low, 5 nonce high, 6 start counter) while the
// unit is idle. Push message words on the req_ side: one 8-byte little-endian
// word per transfer, with its byte count and a last flag closing the message.
// Pop results from the rsp_ side: each word comes back XORed with keystream,
// bytes past the count zeroed, count and last copied through.
// A front stage tracks the block counter and word position and queues each
// word; a back stage builds keystream blocks with one round per cycle and
// XORs words into an output register.
// A word that opens a block waits in the queue through the rounds and the
// final pass before it is XORed into the output register; other words go
// from the queue straight to the output register. Each block then serves up
// to eight words at one per cycle while the output register is free. The
// queue keeps taking words while the round unit is busy.
// Reset clears the configuration to zero and empties queue and output.
// When the consumer stalls, the result holds; the queue fills and then
// req_full rises.
`include "chacha20_keystream_xor_unit_assert.svh"

module chacha20_keystream_xor_unit
   import cc20_pkg::*;
#(
   parameter int unsigned DOUBLE_ROUNDS = 10,
   parameter int unsigned QUEUE_DEPTH   = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   cfg_type       cfg_ff;
   logic [31:0]   start_counter_ff;

   logic          q_push;
   job_type       q_job;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   job_type       q_head;
   bk_status_type bk_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         start_counter_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_KEY_0:         cfg_ff.key_0      <= csr_wdata;
            CSR_KEY_1:         cfg_ff.key_1      <= csr_wdata;
            CSR_KEY_2:         cfg_ff.key_2      <= csr_wdata;
            CSR_KEY_3:         cfg_ff.key_3      <= csr_wdata;
            CSR_NONCE_LOW:     cfg_ff.nonce_low  <= csr_wdata;
            CSR_NONCE_HIGH:    cfg_ff.nonce_high <= csr_wdata[31:0];
            CSR_START_COUNTER: start_counter_ff  <= csr_wdata[31:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   assign req_full = q_full;

   cc20_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .start_counter (start_counter_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (q_job)
   );

   cc20_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   cc20_back #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .status    (bk_status)
   );

   `CC20_ASSERT_NEXT(a_accept_fills_queue, clock, reset, req_push && !req_full, !q_empty)
   `CC20_ASSERT_NOW(a_no_pop_while_busy, clock, reset, bk_status.busy, !q_pop && !bk_status.emit)
   `CC20_ASSERT_NEXT(a_pop_gives_result, clock, reset, q_pop, !rsp_empty)

endmodule
